// File: hw/rtl/reep_pkg.sv
// ----------------------------------------------------------------------------
// reep_pkg
// Shared types and constants of the region enter/exit profiler.
// ----------------------------------------------------------------------------
package reep_pkg;

  localparam int REGION_COUNT = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int REGION_W     = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  localparam int CMD_W      = 2;
  localparam int REGION_IN_W = 8;
  localparam int TIME_W     = 64;
  localparam int OUT_CNT_W  = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENTER = 2'd0,
    CMD_EXIT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_STATE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMING_ENABLE = 1'd0,
    CFG_PULSE_ENABLE  = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_FETCH  = 2'd1,
    S_DIFF   = 2'd2,
    S_UPDATE = 2'd3
  } state_t;

  typedef struct packed {
    logic take;
    logic fetch;
    logic diff;
    logic update;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // Result item packing, lowest bit first
  localparam int O_STATUS = 0;
  localparam int O_ENTRY  = 2;
  localparam int O_EXIT   = 34;
  localparam int O_TOTAL  = 66;
  localparam int O_LAST   = 130;
  localparam int O_OPEN   = 194;
  localparam int O_FIRE   = 195;
  localparam int O_ENTER  = 196;

endpackage

// File: hw/rtl/reep_ctrl.sv
// ----------------------------------------------------------------------------
// reep_ctrl
// Sequencer of one item: take, fetch the region row, form the elapsed time,
// update the row and issue the result.
// ----------------------------------------------------------------------------
module reep_ctrl
  import reep_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctrl_t    ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.take  = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ctrl.fetch = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        ctrl.diff  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!stat.out_busy) begin
          ctrl.update = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/reep_dp.sv
// ----------------------------------------------------------------------------
// reep_dp
// Region table, configuration registers, elapsed time arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module reep_dp
  import reep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  ctrl_t                 ctrl,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic timing_enable;
  logic pulse_enable;

  logic [COUNT_WIDTH-1:0] entries_store     [REGION_COUNT];
  logic [COUNT_WIDTH-1:0] exits_store       [REGION_COUNT];
  logic [TIME_W-1:0]      enter_stamp_store [REGION_COUNT];
  logic [TIME_W-1:0]      elapsed_store     [REGION_COUNT];
  logic                   open_flags        [REGION_COUNT];
  logic [REGION_COUNT-1:0] row_valid;

  cmd_t                   cmd_q;
  logic [REGION_W-1:0]    idx_q;
  logic                   in_range;
  logic [TIME_W-1:0]      now_q;

  logic [COUNT_WIDTH-1:0] ent_r;
  logic [COUNT_WIDTH-1:0] ext_r;
  logic [TIME_W-1:0]      stamp_r;
  logic [TIME_W-1:0]      elap_r;
  logic                   open_r;

  logic [TIME_W-1:0]      diff;
  logic                   now_ge;

  logic [TIME_W:0]        sub_full;
  cmd_t                   in_cmd;
  logic [REGION_IN_W-1:0] in_region;

  logic [COUNT_WIDTH-1:0] ent_new;
  logic [COUNT_WIDTH-1:0] ext_new;
  logic [TIME_W-1:0]      stamp_new;
  logic [TIME_W-1:0]      elap_new;
  logic                   open_new;
  logic                   row_write;
  status_t                status_new;
  logic                   fire_new;
  logic                   entering_new;
  logic                   show_stats;

  logic [COUNT_WIDTH+OUT_CNT_W-1:0] ent_ext;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext_ext;
  logic [OUT_DATA_W-1:0]            out_next;

  assign in_cmd    = cmd_t'(in_data[CMD_W-1:0]);
  assign in_region = in_data[CMD_W +: REGION_IN_W];
  assign sub_full  = {1'b0, now_q} - {1'b0, stamp_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_enable <= 1'b1;
      pulse_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TIMING_ENABLE: timing_enable <= cfg_data[0];
        CFG_PULSE_ENABLE:  pulse_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cmd_q    <= in_cmd;
      idx_q    <= in_region[REGION_W-1:0];
      in_range <= ({1'b0, in_region} < 9'(REGION_COUNT));
      now_q    <= timing_enable ? in_data[CMD_W+REGION_IN_W +: TIME_W] : '0;
    end
  end

  // Fetch the row; a row not written since clear reads as zero
  always_ff @(posedge clk) begin
    if (ctrl.fetch) begin
      if (in_range && row_valid[idx_q]) begin
        ent_r   <= entries_store[idx_q];
        ext_r   <= exits_store[idx_q];
        stamp_r <= enter_stamp_store[idx_q];
        elap_r  <= elapsed_store[idx_q];
        open_r  <= open_flags[idx_q];
      end else begin
        ent_r   <= '0;
        ext_r   <= '0;
        stamp_r <= '0;
        elap_r  <= '0;
        open_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff) begin
      diff   <= sub_full[TIME_W-1:0];
      now_ge <= ~sub_full[TIME_W];
    end
  end

  always_comb begin
    ent_new      = ent_r;
    ext_new      = ext_r;
    stamp_new    = stamp_r;
    elap_new     = elap_r;
    open_new     = open_r;
    row_write    = 1'b0;
    status_new   = ST_OK;
    fire_new     = 1'b0;
    entering_new = 1'b0;
    show_stats   = in_range;
    priority if (cmd_q == CMD_CLEAR) begin
      ent_new   = '0;
      ext_new   = '0;
      stamp_new = '0;
      elap_new  = '0;
      open_new  = 1'b0;
    end else if (!in_range) begin
      status_new = ST_RANGE;
    end else if (cmd_q == CMD_ENTER) begin
      ent_new      = ent_r + 1'b1;
      stamp_new    = now_q;
      open_new     = 1'b1;
      row_write    = 1'b1;
      fire_new     = pulse_enable;
      entering_new = pulse_enable;
    end else if (cmd_q == CMD_EXIT) begin
      ext_new   = ext_r + 1'b1;
      row_write = 1'b1;
      fire_new  = pulse_enable;
      if (open_r) begin
        if (now_ge) begin
          elap_new = elap_r + diff;
        end
        open_new = 1'b0;
      end else begin
        status_new = ST_STATE;
      end
    end else begin
      row_write = 1'b0;
    end
  end

  assign ent_ext = {{OUT_CNT_W{1'b0}}, ent_new};
  assign ext_ext = {{OUT_CNT_W{1'b0}}, ext_new};

  // Write back the row
  always_ff @(posedge clk) begin
    if (ctrl.update && row_write) begin
      entries_store[idx_q]     <= ent_new;
      exits_store[idx_q]       <= ext_new;
      enter_stamp_store[idx_q] <= stamp_new;
      elapsed_store[idx_q]     <= elap_new;
      open_flags[idx_q]        <= open_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctrl.update) begin
      if (cmd_q == CMD_CLEAR) begin
        row_valid <= '0;
      end else if (row_write) begin
        row_valid[idx_q] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_next                         = '0;
    out_next[O_STATUS +: 2]          = status_new;
    out_next[O_FIRE]                 = fire_new;
    out_next[O_ENTER]                = entering_new;
    if (show_stats) begin
      out_next[O_ENTRY +: OUT_CNT_W] = ent_ext[OUT_CNT_W-1:0];
      out_next[O_EXIT +: OUT_CNT_W]  = ext_ext[OUT_CNT_W-1:0];
      out_next[O_TOTAL +: TIME_W]    = elap_new;
      out_next[O_LAST +: TIME_W]     = stamp_new;
      out_next[O_OPEN]               = open_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      out_data <= out_next;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

// File: hw/rtl/region_enter_exit_profiler_top.sv
// ----------------------------------------------------------------------------
// region_enter_exit_profiler_top
// Per-region profiling table with enter, exit, clear and read commands.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. The block works on one
// item at a time: the sequencer takes the item, fetches the region row,
// forms the elapsed time and updates the row, which loads the result
// register; no new item is accepted before the previous one has updated its
// row. While a result is held in the output register, the next item waits in
// the update step. A finished result waits in the output register while the
// next item is already accepted. Clear empties the whole table at once
// through per-region valid bits; there is no clearing pass after reset.
// Out-of-range enter, exit and read items return status 1 with all other
// fields zero. The timing enable is sampled when an item is taken; the pulse
// enable is applied when the item updates its row.
module region_enter_exit_profiler_top
  import reep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cmd[1:0], region[9:2], now_time[73:10], zero fill[79:74]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[1:0], entry_count[33:2], exit_count[65:34], total_time[129:66],
  // last_enter_time[193:130], region_open[194], pulse_fire[195],
  // pulse_entering[196], zero fill[199:197]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  reep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  reep_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: hw/rtl/reep_checker.sv
// ----------------------------------------------------------------------------
// reep_checker
// Port-level checks of the profiler, bound to the top level.
// ----------------------------------------------------------------------------
module reep_checker
  import reep_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[O_STATUS +: 2] == ST_RANGE
      |-> m_axis_tdata[OUT_DATA_W-1:O_ENTRY] == '0)
    else $error("range error result carries data");

  a_entering_fire: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[O_ENTER] |-> m_axis_tdata[O_FIRE]
      && m_axis_tdata[O_OPEN])
    else $error("enter pulse without fire or open region");

  a_state_closed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[O_STATUS +: 2] == ST_STATE
      |-> !m_axis_tdata[O_OPEN] && !m_axis_tdata[O_ENTER])
    else $error("state error on open region");

endmodule

bind region_enter_exit_profiler_top reep_checker u_reep_checker (.*);
